[rtl/bptc_pkg.sv]
`timescale 1ns / 1ps

package bptc_pkg;

    localparam int unsigned CALIB_W = 48;
    localparam int unsigned RAW_W   = 20;

    localparam logic [63:0] TFINE_OFFSET = 64'd128000;
    localparam logic [63:0] PRESS_BASE   = 64'd1048576;
    localparam logic [63:0] PRESS_SCALE  = 64'd3125;
    localparam logic [31:0] ROUND_HALF   = 32'd128;
    localparam logic [63:0] DEN_BIAS     = 64'h0000_8000_0000_0000;

    typedef logic [63:0] word_t;

    function automatic word_t sx16(input logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    function automatic word_t zx16(input logic [15:0] v);
        return {48'd0, v};
    endfunction

    function automatic word_t sx32(input logic [31:0] v);
        return {{32{v[31]}}, v};
    endfunction

    function automatic logic [31:0] asr32(input logic [31:0] x, input logic [5:0] n);
        return 32'($signed(x) >>> n);
    endfunction

    function automatic word_t asr64(input word_t x, input logic [5:0] n);
        return 64'($signed(x) >>> n);
    endfunction

endpackage

[rtl/baro_pressure_temp_compensation.sv]
`timescale 1ns / 1ps

// Channel  Dir  Beat fields
// s_*      in   tdata: press_msb, press_lsb, press_xlsb, temp_msb, temp_lsb, temp_xlsb;
//               tuser: read_ok
// m_*      out  tdata: temperature_centi, pressure_pa; tuser: fresh
// APB      in   calib_temp @0x00, calib_press_a @0x08, calib_press_b @0x10, calib_press_c @0x18
//
// A frame runs from accept to the next accept, while the output is free, through:
// 22 sequencer steps, 13 wrapping 64-bit multiplies on a shared 32x32 multiplier,
// a restoring divider, the output step and the idle step.
// A zero pressure divisor skips the divider and the correction terms.
// s_tready is high only while the sequencer is idle; a finished result waits in
// the output register while the next frame is accepted, and a result still held
// there stalls the sequencer in its output step until m_tready.
// Reset clears the calibration registers and the held raw values.

module baro_pressure_temp_compensation
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] press_msb, [15:8] press_lsb, [23:16] press_xlsb,
    // [31:24] temp_msb, [39:32] temp_lsb, [47:40] temp_xlsb
    input  logic [47:0] s_tdata,
    // [0] read_ok
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [19:0] temperature_centi, [43:20] pressure_pa, [47:44] zero
    output logic [47:0] m_tdata,
    // [0] fresh
    output logic        m_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RUN  = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    localparam logic [4:0] K_T0   = 5'd0;
    localparam logic [4:0] K_T1   = 5'd1;
    localparam logic [4:0] K_T2   = 5'd2;
    localparam logic [4:0] K_T3   = 5'd3;
    localparam logic [4:0] K_X1   = 5'd4;
    localparam logic [4:0] K_X2A  = 5'd5;
    localparam logic [4:0] K_X2B  = 5'd6;
    localparam logic [4:0] K_X2C  = 5'd7;
    localparam logic [4:0] K_X2D  = 5'd8;
    localparam logic [4:0] K_X1A  = 5'd9;
    localparam logic [4:0] K_X1B  = 5'd10;
    localparam logic [4:0] K_DEN0 = 5'd11;
    localparam logic [4:0] K_DEN1 = 5'd12;
    localparam logic [4:0] K_NUM0 = 5'd13;
    localparam logic [4:0] K_NUM1 = 5'd14;
    localparam logic [4:0] K_DIV  = 5'd15;
    localparam logic [4:0] K_P0   = 5'd16;
    localparam logic [4:0] K_P1   = 5'd17;
    localparam logic [4:0] K_P2   = 5'd18;
    localparam logic [4:0] K_P3   = 5'd19;
    localparam logic [4:0] K_P4   = 5'd20;
    localparam logic [4:0] K_P5   = 5'd21;

    localparam logic [1:0] R_TEMP = 2'd0;
    localparam logic [1:0] R_PA   = 2'd1;
    localparam logic [1:0] R_PB   = 2'd2;
    localparam logic [1:0] R_PC   = 2'd3;

    logic [bptc_pkg::CALIB_W-1:0] calib_temp_reg, calib_press_a_reg;
    logic [bptc_pkg::CALIB_W-1:0] calib_press_b_reg, calib_press_c_reg;
    logic [bptc_pkg::RAW_W-1:0]   adc_p_reg, adc_t_reg;
    logic        fresh_reg;
    logic [2:0]  state_reg;
    logic [4:0]  step_reg;
    logic [1:0]  mul_ph_reg;
    bptc_pkg::word_t mul_a_reg, mul_b_reg, prod_reg, acc_reg;
    bptc_pkg::word_t x1_reg, x2_reg, tmp_reg, p_reg, den_reg;
    logic [31:0] tfine_reg;
    logic [19:0] temp_out_reg;
    logic [23:0] press_out_reg;
    bptc_pkg::word_t div_rem_reg, div_quo_reg, div_dm_reg;
    logic        div_neg_reg;
    logic [5:0]  div_cnt_reg;
    logic        m_tvalid_reg;
    logic [47:0] m_tdata_reg;
    logic        m_tuser_reg;

    logic [15:0] t1, t2, t3;
    logic [31:0] diff_a, diff_d, tfine_next, tcent;
    logic [31:0] mul_x, mul_y;
    bptc_pkg::word_t prod_comb, x1_comb, num_abs, den_abs, quo_next, p_final;
    logic [64:0] div_sh;
    logic        div_ge;
    logic        cfg_wr;

    assign t1 = calib_temp_reg[15:0];
    assign t2 = calib_temp_reg[31:16];
    assign t3 = calib_temp_reg[47:32];

    assign diff_a = {15'd0, adc_t_reg[19:3]} - {15'd0, t1, 1'b0};
    assign diff_d = {16'd0, adc_t_reg[19:4]} - {16'd0, t1};
    assign tfine_next = tfine_reg + bptc_pkg::asr32(acc_reg[31:0], 6'd14);
    assign tcent = bptc_pkg::asr32({tfine_reg[29:0], 2'b00} + tfine_reg
                                   + bptc_pkg::ROUND_HALF, 6'd8);
    assign x1_comb = bptc_pkg::sx32(tfine_reg) - bptc_pkg::TFINE_OFFSET;

    // shared multiplier: low x low, low x high, high x low
    assign mul_x = (mul_ph_reg == 2'd2) ? mul_a_reg[63:32] : mul_a_reg[31:0];
    assign mul_y = (mul_ph_reg == 2'd1) ? mul_b_reg[63:32] : mul_b_reg[31:0];
    assign prod_comb = {32'd0, mul_x} * {32'd0, mul_y};

    assign num_abs = acc_reg[63] ? (64'd0 - acc_reg) : acc_reg;
    assign den_abs = den_reg[63] ? (64'd0 - den_reg) : den_reg;
    assign div_sh = {div_rem_reg, div_quo_reg[63]};
    assign div_ge = div_sh >= {1'b0, div_dm_reg};
    assign quo_next = {div_quo_reg[62:0], div_ge};
    assign p_final = bptc_pkg::asr64(x1_reg, 6'd8)
                   + {{44{calib_press_c_reg[15]}}, calib_press_c_reg[15:0], 4'd0};

    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    always_comb
    begin
        case (paddr[4:3])
            R_TEMP:  prdata = {16'd0, calib_temp_reg};
            R_PA:    prdata = {16'd0, calib_press_a_reg};
            R_PB:    prdata = {16'd0, calib_press_b_reg};
            R_PC:    prdata = {16'd0, calib_press_c_reg};
            default: prdata = 64'd0;
        endcase
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            calib_temp_reg    <= '0;
            calib_press_a_reg <= '0;
            calib_press_b_reg <= '0;
            calib_press_c_reg <= '0;
            adc_p_reg    <= '0;
            adc_t_reg    <= '0;
            fresh_reg    <= 1'b0;
            state_reg    <= S_IDLE;
            step_reg     <= K_T0;
            mul_ph_reg   <= 2'd0;
            mul_a_reg    <= '0;
            mul_b_reg    <= '0;
            prod_reg     <= '0;
            acc_reg      <= '0;
            x1_reg       <= '0;
            x2_reg       <= '0;
            tmp_reg      <= '0;
            p_reg        <= '0;
            den_reg      <= '0;
            tfine_reg    <= '0;
            temp_out_reg <= '0;
            press_out_reg <= '0;
            div_rem_reg  <= '0;
            div_quo_reg  <= '0;
            div_dm_reg   <= '0;
            div_neg_reg  <= 1'b0;
            div_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            m_tuser_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                case (paddr[4:3])
                    R_TEMP:  calib_temp_reg    <= pwdata[47:0];
                    R_PA:    calib_press_a_reg <= pwdata[47:0];
                    R_PB:    calib_press_b_reg <= pwdata[47:0];
                    R_PC:    calib_press_c_reg <= pwdata[47:0];
                    default: ;
                endcase
            end

            // the output step reloads the register itself
            if (m_tvalid_reg && m_tready && (state_reg != S_OUT))
                m_tvalid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        if (s_tuser)
                        begin
                            adc_p_reg <= {s_tdata[7:0], s_tdata[15:8], s_tdata[23:20]};
                            adc_t_reg <= {s_tdata[31:24], s_tdata[39:32], s_tdata[47:44]};
                        end
                        fresh_reg <= s_tuser;
                        step_reg  <= K_T0;
                        state_reg <= S_RUN;
                    end
                end
                S_MUL:
                begin
                    prod_reg   <= prod_comb;
                    mul_ph_reg <= mul_ph_reg + 2'd1;
                    case (mul_ph_reg)
                        2'd0: ;
                        2'd1: acc_reg <= prod_reg;
                        default: acc_reg <= acc_reg + {prod_reg[31:0], 32'd0};
                    endcase
                    if (mul_ph_reg == 2'd3)
                        state_reg <= S_RUN;
                end
                S_DIV:
                begin
                    div_rem_reg <= div_ge ? 64'(div_sh - {1'b0, div_dm_reg}) : div_sh[63:0];
                    div_quo_reg <= quo_next;
                    div_cnt_reg <= div_cnt_reg + 6'd1;
                    if (div_cnt_reg == 6'd63)
                    begin
                        p_reg     <= div_neg_reg ? (64'd0 - quo_next) : quo_next;
                        state_reg <= S_RUN;
                    end
                end
                S_OUT:
                begin
                    // hold until the output register is free
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {4'd0, press_out_reg, temp_out_reg};
                        m_tuser_reg  <= fresh_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                S_RUN:
                begin
                    step_reg <= step_reg + 5'd1;
                    mul_ph_reg <= 2'd0;
                    case (step_reg)
                        K_T0:
                        begin
                            mul_a_reg <= bptc_pkg::sx32(diff_a);
                            mul_b_reg <= bptc_pkg::sx16(t2);
                            state_reg <= S_MUL;
                        end
                        K_T1:
                        begin
                            tfine_reg <= bptc_pkg::asr32(acc_reg[31:0], 6'd11);
                            mul_a_reg <= bptc_pkg::sx32(diff_d);
                            mul_b_reg <= bptc_pkg::sx32(diff_d);
                            state_reg <= S_MUL;
                        end
                        K_T2:
                        begin
                            mul_a_reg <= bptc_pkg::sx32(bptc_pkg::asr32(acc_reg[31:0], 6'd12));
                            mul_b_reg <= bptc_pkg::sx16(t3);
                            state_reg <= S_MUL;
                        end
                        K_T3:
                            tfine_reg <= tfine_next;
                        K_X1:
                        begin
                            temp_out_reg <= tcent[19:0];
                            x1_reg    <= x1_comb;
                            mul_a_reg <= x1_comb;
                            mul_b_reg <= x1_comb;
                            state_reg <= S_MUL;
                        end
                        K_X2A:
                        begin
                            tmp_reg   <= acc_reg;
                            mul_a_reg <= acc_reg;
                            mul_b_reg <= bptc_pkg::sx16(calib_press_b_reg[47:32]);
                            state_reg <= S_MUL;
                        end
                        K_X2B:
                        begin
                            x2_reg    <= acc_reg;
                            mul_a_reg <= x1_reg;
                            mul_b_reg <= bptc_pkg::sx16(calib_press_b_reg[31:16]);
                            state_reg <= S_MUL;
                        end
                        K_X2C:
                            x2_reg <= x2_reg + {acc_reg[46:0], 17'd0};
                        K_X2D:
                        begin
                            x2_reg <= x2_reg
                                    + {{13{calib_press_b_reg[15]}}, calib_press_b_reg[15:0],
                                       35'd0};
                            mul_a_reg <= tmp_reg;
                            mul_b_reg <= bptc_pkg::sx16(calib_press_a_reg[47:32]);
                            state_reg <= S_MUL;
                        end
                        K_X1A:
                        begin
                            tmp_reg   <= bptc_pkg::asr64(acc_reg, 6'd8);
                            mul_a_reg <= x1_reg;
                            mul_b_reg <= bptc_pkg::sx16(calib_press_a_reg[31:16]);
                            state_reg <= S_MUL;
                        end
                        K_X1B:
                            x1_reg <= tmp_reg + {acc_reg[51:0], 12'd0};
                        K_DEN0:
                        begin
                            mul_a_reg <= x1_reg + bptc_pkg::DEN_BIAS;
                            mul_b_reg <= bptc_pkg::zx16(calib_press_a_reg[15:0]);
                            state_reg <= S_MUL;
                        end
                        K_DEN1:
                        begin
                            den_reg <= bptc_pkg::asr64(acc_reg, 6'd33);
                            p_reg   <= bptc_pkg::PRESS_BASE - {44'd0, adc_p_reg};
                        end
                        K_NUM0:
                        begin
                            if (den_reg == 64'd0)
                            begin
                                press_out_reg <= 24'd0;
                                state_reg     <= S_OUT;
                            end
                            else
                                tmp_reg <= {p_reg[32:0], 31'd0} - x2_reg;
                        end
                        K_NUM1:
                        begin
                            mul_a_reg <= tmp_reg;
                            mul_b_reg <= bptc_pkg::PRESS_SCALE;
                            state_reg <= S_MUL;
                        end
                        K_DIV:
                        begin
                            div_rem_reg <= '0;
                            div_quo_reg <= num_abs;
                            div_dm_reg  <= den_abs;
                            div_neg_reg <= acc_reg[63] ^ den_reg[63];
                            div_cnt_reg <= '0;
                            state_reg   <= S_DIV;
                        end
                        K_P0:
                        begin
                            tmp_reg   <= bptc_pkg::asr64(p_reg, 6'd13);
                            mul_a_reg <= bptc_pkg::sx16(calib_press_c_reg[47:32]);
                            mul_b_reg <= bptc_pkg::asr64(p_reg, 6'd13);
                            state_reg <= S_MUL;
                        end
                        K_P1:
                        begin
                            mul_a_reg <= acc_reg;
                            mul_b_reg <= tmp_reg;
                            state_reg <= S_MUL;
                        end
                        K_P2:
                        begin
                            x2_reg    <= bptc_pkg::asr64(acc_reg, 6'd25);
                            mul_a_reg <= bptc_pkg::sx16(calib_press_c_reg[31:16]);
                            mul_b_reg <= p_reg;
                            state_reg <= S_MUL;
                        end
                        K_P3:
                        begin
                            tmp_reg <= bptc_pkg::asr64(acc_reg, 6'd19);
                            x1_reg  <= p_reg + x2_reg;
                        end
                        K_P4:
                            x1_reg <= x1_reg + tmp_reg;
                        K_P5:
                        begin
                            press_out_reg <= p_final[31:8];
                            state_reg     <= S_OUT;
                        end
                        default:
                            state_reg <= S_OUT;
                    endcase
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    a_mul_phase_in_mul: assert property (@(posedge clk) disable iff (!rst_n)
        (mul_ph_reg != 2'd0) |-> (state_reg == S_MUL))
        else $error("multiplier phase advanced outside a multiply");

    a_accept_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == S_RUN && step_reg == K_T0))
        else $error("accepted beat did not start the sequence");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (div_dm_reg != 64'd0))
        else $error("divider running with zero divisor");

    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && (!m_tvalid || m_tready)) |=> (m_tvalid && s_tready))
        else $error("result not loaded into output register");

endmodule
